>>> hw/rtl/paired_threshold_search_defines.svh
// Assertion macros shared by the checker of the paired threshold search.
// No dependencies; include by bare file name.
`ifndef PAIRED_THRESHOLD_SEARCH_DEFINES_SVH
`define PAIRED_THRESHOLD_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pts assertion failed");

`endif

>>> hw/rtl/pts_pkg.sv
// Types and constants of the paired threshold search.
// No dependencies; used by every module of the block.
package pts_pkg;

	localparam int CNT_W = 11;
	localparam int STAT_W = 32;
	localparam int PROD_W = 64;
	localparam int ALPHA_W = 17;
	localparam int IDX_W = 10;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W = 64;
	localparam int RATE_W = ALPHA_W + CNT_W;
	localparam int RHS_W = RATE_W + CNT_W;
	localparam int POS1_W = CNT_W + 1;
	localparam int LHS_W = 2 * POS1_W + 16;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_TEST_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIRST_CAND = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_CAND = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INIT_PROD = 3'd5;

	// -99 in Q16.16, the threshold reported when nothing is found in mode 0.
	localparam logic signed [STAT_W-1:0] NONE_MODE0 = 32'shFF9D0000;

	typedef struct packed {
		logic req_type;
		logic [IDX_W-1:0] entry_index;
		logic signed [STAT_W-1:0] first_stat;
		logic signed [STAT_W-1:0] second_stat;
		logic [IDX_W-1:0] order_entry;
	} req_t;

	typedef struct packed {
		logic signed [STAT_W-1:0] threshold_first;
		logic signed [STAT_W-1:0] threshold_second;
		logic [CNT_W-1:0] best_rejections;
	} res_t;

	typedef struct packed {
		logic valid;
		logic first_row;
		logic [CNT_W-1:0] outer;
		logic [CNT_W-1:0] inner;
		logic signed [STAT_W-1:0] t1;
		logic signed [STAT_W-1:0] other;
		logic signed [STAT_W-1:0] t2;
	} pair_t;

	typedef struct packed {
		logic valid;
		logic feasible;
		logic [CNT_W-1:0] count;
		logic signed [PROD_W-1:0] product;
		logic signed [STAT_W-1:0] t1;
		logic signed [STAT_W-1:0] t2;
	} score_t;

endpackage

>>> hw/rtl/paired_threshold_search.sv
// Paired threshold search. A start transfer walks m1 rows of m2 pairs at one pair a
// cycle within a row and then shows the result. The row rate is set by the single read
// port of the statistic memory, which also fetches the study-1 threshold of each row.
// Reset clears control and configuration; the statistic and order memories hold nothing
// defined until loaded.
module paired_threshold_search
	import pts_pkg::*;
#(
	parameter int MAX_TESTS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic res_valid,
	input logic res_ready,
	output res_t res,
	input logic cfg_we,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_TESTS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_ROW = 3'd2;
	localparam logic [2:0] ST_PAIR = 3'd3;
	localparam logic [2:0] ST_GAP = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;

	logic [CNT_W-1:0] test_count_q;
	logic [CNT_W-1:0] first_cand_q;
	logic [CNT_W-1:0] second_cand_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic mode_q;
	logic signed [PROD_W-1:0] init_prod_q;

	logic [2*STAT_W-1:0] stat_mem [MAX_TESTS];
	logic [IDX_W-1:0] order_mem [MAX_TESTS];
	logic [2*STAT_W-1:0] stat_rdata;
	logic [IDX_W-1:0] order_rdata;

	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0] m1_q;
	logic [CNT_W-1:0] m2_q;
	logic [CNT_W-1:0] m1;
	logic [CNT_W-1:0] m2;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;

	logic row_rd_s1;
	logic signed [STAT_W-1:0] t1_q;
	logic v_s1;
	logic first_s1;
	logic [CNT_W-1:0] i_s1;
	logic [CNT_W-1:0] j_s1;
	logic v_s2;
	logic first_s2;
	logic oob_s2;
	logic [CNT_W-1:0] i_s2;
	logic [CNT_W-1:0] j_s2;

	logic [CNT_W-1:0] top_cnt_q;
	logic signed [PROD_W-1:0] top_prod_q;
	logic signed [STAT_W-1:0] top_first_q;
	logic signed [STAT_W-1:0] top_second_q;

	logic res_valid_q;
	res_t res_q;

	logic [IDX_W+AW-1:0] load_ext;
	logic [CNT_W+AW-1:0] i_ext;
	logic [CNT_W+AW-1:0] j_ext;
	logic [IDX_W+AW-1:0] k_ext;
	logic [AW-1:0] load_addr;
	logic [AW-1:0] stat_addr;
	logic [AW-1:0] order_addr;
	logic load_ok;
	logic mem_we;
	logic k_oob;

	pair_t pair;
	score_t score;
	logic eval_busy;
	logic take;
	logic better;
	logic signed [STAT_W-1:0] none_value;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_count_q <= CNT_W'(1);
			first_cand_q <= '0;
			second_cand_q <= '0;
			alpha_q <= ALPHA_W'(3277);
			mode_q <= 1'b0;
			init_prod_q <= {1'b0, {(PROD_W-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEST_COUNT: test_count_q <= cfg_data[CNT_W-1:0];
				REG_FIRST_CAND: first_cand_q <= cfg_data[CNT_W-1:0];
				REG_SECOND_CAND: second_cand_q <= cfg_data[CNT_W-1:0];
				REG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_MODE: mode_q <= cfg_data[0];
				REG_INIT_PROD: init_prod_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Address forming; positions are zero-extended before they are cut to the memory width.
	always_comb begin
		load_ext = {AW'(0), req.entry_index};
		i_ext = {AW'(0), i_q};
		j_ext = {AW'(0), j_q};
		k_ext = {AW'(0), order_rdata};
		load_addr = load_ext[AW-1:0];
		load_ok = (32'(req.entry_index) < 32'(MAX_TESTS));
		mem_we = req_valid && req_ready && (req.req_type == REQ_LOAD) && load_ok;
		k_oob = (32'(order_rdata) >= 32'(MAX_TESTS));
		order_addr = j_ext[AW-1:0];
		stat_addr = v_s1 ? k_ext[AW-1:0] : i_ext[AW-1:0];
		m1 = (32'(first_cand_q) > 32'(MAX_TESTS)) ? CNT_W'(MAX_TESTS) : first_cand_q;
		m2 = (32'(second_cand_q) > 32'(MAX_TESTS)) ? CNT_W'(MAX_TESTS) : second_cand_q;
		none_value = mode_q ? '0 : NONE_MODE0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stat_mem[load_addr] <= {req.first_stat, req.second_stat};
			order_mem[load_addr] <= req.order_entry;
		end
		stat_rdata <= stat_mem[stat_addr];
		order_rdata <= order_mem[order_addr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req.req_type == REQ_START) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					i_q <= '0;
					j_q <= '0;
					state_q <= (m1 == '0 || m2 == '0) ? ST_DRAIN : ST_ROW;
				end
				ST_ROW: state_q <= ST_PAIR;
				ST_PAIR: begin
					if (j_q == m2_q - CNT_W'(1)) begin
						j_q <= '0;
						if (i_q == m1_q - CNT_W'(1)) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + CNT_W'(1);
							state_q <= ST_GAP;
						end
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_GAP: state_q <= ST_ROW;
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !eval_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			rate_q <= RATE_W'(alpha_q) * RATE_W'(test_count_q);
			m1_q <= m1;
			m2_q <= m2;
		end
		if (row_rd_s1) begin
			t1_q <= stat_rdata[2*STAT_W-1:STAT_W];
		end
		if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.threshold_first <= top_first_q;
			res_q.threshold_second <= top_second_q;
			res_q.best_rejections <= top_cnt_q;
		end
	end

	// Read pipeline: order entry, then the statistics at that position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_rd_s1 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			row_rd_s1 <= (state_q == ST_ROW);
			v_s1 <= (state_q == ST_PAIR);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (j_q == '0);
		i_s1 <= i_q;
		j_s1 <= j_q;
		first_s2 <= first_s1;
		i_s2 <= i_s1;
		j_s2 <= j_s1;
		oob_s2 <= k_oob;
	end

	always_comb begin
		pair.valid = v_s2;
		pair.first_row = first_s2;
		pair.outer = i_s2;
		pair.inner = j_s2;
		pair.t1 = t1_q;
		pair.other = oob_s2 ? '0 : stat_rdata[2*STAT_W-1:STAT_W];
		pair.t2 = oob_s2 ? '0 : stat_rdata[STAT_W-1:0];
	end

	pts_pair_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.pval_mode(mode_q),
		.rate_base(rate_q),
		.score(score),
		.busy(eval_busy)
	);

	// A larger count wins; an equal count wins on a strictly better product.
	always_comb begin
		better = mode_q ? (score.product > top_prod_q) : (score.product < top_prod_q);
		take = score.valid && score.feasible &&
			((score.count > top_cnt_q) || (score.count == top_cnt_q && better));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_cnt_q <= '0;
			top_prod_q <= '0;
			top_first_q <= '0;
			top_second_q <= '0;
		end else if (state_q == ST_START) begin
			top_cnt_q <= '0;
			top_prod_q <= mode_q ? '0 : init_prod_q;
			top_first_q <= none_value;
			top_second_q <= none_value;
		end else if (take) begin
			top_cnt_q <= score.count;
			top_prod_q <= score.product;
			top_first_q <= score.t1;
			top_second_q <= score.t2;
		end
	end

endmodule

>>> hw/rtl/pts_pair_eval.sv
// Pair evaluation pipeline: rejection count, feasibility and product.
// Depends on pts_pkg.
module pts_pair_eval
	import pts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input pair_t pair,
	input logic pval_mode,
	input logic [RATE_W-1:0] rate_base,
	output score_t score,
	output logic busy
);

	logic [CNT_W-1:0] run_q;
	logic hit;
	logic [CNT_W-1:0] run_next;

	logic v_s3;
	logic [CNT_W-1:0] cnt_s3;
	logic [CNT_W-1:0] rmax_s3;
	logic [2*POS1_W-1:0] lhs_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [STAT_W-1:0] t1_s3;
	logic signed [STAT_W-1:0] t2_s3;

	logic [RHS_W-1:0] rhs;
	logic [LHS_W-1:0] lhs_full;

	always_comb begin
		hit = pval_mode ? (pair.other <= pair.t1) : (pair.other >= pair.t1);
		run_next = (pair.first_row ? '0 : run_q) + CNT_W'(hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= pair.valid;
			if (pair.valid) begin
				run_q <= run_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_s3 <= run_next;
		rmax_s3 <= (run_next == '0) ? CNT_W'(1) : run_next;
		lhs_s3 <= (POS1_W'(pair.outer) + POS1_W'(1)) * (POS1_W'(pair.inner) + POS1_W'(1));
		prod_s3 <= PROD_W'(pair.t1) * PROD_W'(pair.t2);
		t1_s3 <= pair.t1;
		t2_s3 <= pair.t2;
	end

	// The pair is feasible when (i+1)(j+1)*65536 <= alpha*m*max(R,1).
	always_comb begin
		rhs = RHS_W'(rate_base) * RHS_W'(rmax_s3);
		lhs_full = {lhs_s3, 16'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score <= '0;
		end else begin
			score.valid <= v_s3;
			score.feasible <= (lhs_full <= LHS_W'(rhs));
			score.count <= cnt_s3;
			score.product <= prod_s3;
			score.t1 <= t1_s3;
			score.t2 <= t2_s3;
		end
	end

	assign busy = v_s3 | score.valid;

endmodule

>>> hw/rtl/pts_checker.sv
// Port-level checks of the paired threshold search, bound to the top level.
// Depends on pts_pkg and paired_threshold_search_defines.svh.
`include "paired_threshold_search_defines.svh"

module pts_checker
	import pts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// A waiting result is held until its transfer.
	`PTS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res))

	// A start transfer closes the request side while the search runs.
	`PTS_ASSERT_NEXT(a_start_busy, clk, arst_n, req_valid && req_ready && req.req_type == REQ_START, !req_ready)

	// A new result only appears after the request side was closed for a search.
	`PTS_ASSERT_NOW(a_res_after_search, clk, arst_n, $rose(res_valid), !$past(req_ready))

	// A result never shows while loads are still being taken in the same search.
	`PTS_ASSERT_NEXT(a_load_no_result, clk, arst_n, req_valid && req_ready && req.req_type == REQ_LOAD && !res_valid, !res_valid)

endmodule

bind paired_threshold_search pts_checker u_pts_checker (.*);

>>> sim/paired_threshold_search_test.sv
// Self-checking testbench for the paired threshold search: loads statistics, runs searches
// under several register settings and compares every result with a built-in predictor.
// Depends on pts_pkg and the paired_threshold_search module.
module paired_threshold_search_test;
	import pts_pkg::*;

	localparam int DEPTH = 1024;
	localparam longint CYCLE_LIMIT = 64'd40000000;

	class search_scoreboard;
		logic [CNT_W-1:0] tests_m;
		logic [CNT_W-1:0] rows_m1;
		logic [CNT_W-1:0] cols_m2;
		logic [ALPHA_W-1:0] alpha;
		logic p_mode;
		logic signed [PROD_W-1:0] start_product;
		logic signed [STAT_W-1:0] stat1 [DEPTH];
		logic signed [STAT_W-1:0] stat2 [DEPTH];
		logic [IDX_W-1:0] rank [DEPTH];
		res_t pending_results [$];
		int mismatches;

		function new();
			tests_m = 1;
			rows_m1 = 0;
			cols_m2 = 0;
			alpha = 3277;
			p_mode = 0;
			start_product = 64'sh7FFFFFFFFFFFFFFF;
			mismatches = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_TEST_COUNT: tests_m = v[CNT_W-1:0];
				REG_FIRST_CAND: rows_m1 = v[CNT_W-1:0];
				REG_SECOND_CAND: cols_m2 = v[CNT_W-1:0];
				REG_ALPHA: alpha = v[ALPHA_W-1:0];
				REG_MODE: p_mode = v[0];
				REG_INIT_PROD: start_product = v;
				default: ;
			endcase
		endfunction

		// Notes an accepted input: a load updates the stores, a start predicts a result.
		function void note_request(req_t r);
			int m1, m2, cnt, best;
			longint t1, t2, other, prod, best_prod, bf, bs;
			longint unsigned lhs, rhs;
			res_t e;
			if (r.req_type == REQ_LOAD) begin
				stat1[r.entry_index] = r.first_stat;
				stat2[r.entry_index] = r.second_stat;
				rank[r.entry_index] = r.order_entry;
				return;
			end
			m1 = rows_m1 > DEPTH ? DEPTH : rows_m1;
			m2 = cols_m2 > DEPTH ? DEPTH : cols_m2;
			best = 0;
			best_prod = p_mode ? 0 : start_product;
			bf = p_mode ? 0 : NONE_MODE0;
			bs = bf;
			for (int i = 0; i < m1; i++) begin
				t1 = stat1[i];
				cnt = 0;
				for (int j = 0; j < m2; j++) begin
					other = stat1[rank[j]];
					t2 = stat2[rank[j]];
					if (p_mode ? (other <= t1) : (other >= t1))
						cnt++;
					lhs = longint'(i + 1) * longint'(j + 1) * 65536;
					rhs = longint'(alpha) * longint'(tests_m) * longint'(cnt > 0 ? cnt : 1);
					if (lhs > rhs)
						continue;
					prod = t1 * t2;
					if (cnt > best) begin
						best = cnt;
						best_prod = prod;
						bf = t1;
						bs = t2;
					end
					if (cnt == best && (p_mode ? (prod > best_prod) : (prod < best_prod))) begin
						best_prod = prod;
						bf = t1;
						bs = t2;
					end
				end
			end
			e.threshold_first = bf[STAT_W-1:0];
			e.threshold_second = bs[STAT_W-1:0];
			e.best_rejections = best[CNT_W-1:0];
			pending_results.push_back(e);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			e = pending_results.pop_front();
			if (got.threshold_first !== e.threshold_first ||
					got.threshold_second !== e.threshold_second ||
					got.best_rejections !== e.best_rejections) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h %h %0d, got %h %h %0d",
						e.threshold_first, e.threshold_second, e.best_rejections,
						got.threshold_first, got.threshold_second, got.best_rejections);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 0;
	res_t res;
	logic cfg_we = 0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	search_scoreboard board;
	longint cycles = 0;
	int stall_mode = 0;

	paired_threshold_search dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("paired_threshold_search_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && res_ready)
			board.check_result(res);

	// The receiver stalls on a pattern that changes over the run.
	always @(negedge clk) begin
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= ($urandom_range(0, 3) != 0);
			2: res_ready <= cycles[3];
			default: res_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// Driven with blocking assignments at the falling edge so that back-to-back
	// transfers can lower and raise valid in the same time step.
	task automatic send(req_t r);
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		board.note_request(r);
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic send_burst_gap();
		repeat ($urandom_range(0, 3)) @(negedge clk);
	endtask

	task automatic load(int idx, logic [31:0] a, logic [31:0] b, int ord);
		req_t r;
		r.req_type = REQ_LOAD;
		r.entry_index = IDX_W'(idx);
		r.first_stat = a;
		r.second_stat = b;
		r.order_entry = IDX_W'(ord);
		send(r);
	endtask

	task automatic start_search();
		req_t r;
		r = '0;
		r.req_type = REQ_START;
		r.entry_index = IDX_W'($urandom);
		r.first_stat = $urandom;
		r.second_stat = $urandom;
		r.order_entry = IDX_W'($urandom);
		send(r);
	endtask

	task automatic drain();
		while (board.pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_index = idx;
		cfg_data = v;
		cfg_we = 1'b1;
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] rand_stat();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return $urandom_range(0, 8) << 16;
			default: return $urandom;
		endcase
	endfunction

	// Orders must point at written positions, so they stay below the written span.
	task automatic fill(int n);
		for (int i = 0; i < n; i++) begin
			load(i, rand_stat(), rand_stat(), $urandom_range(0, n - 1));
			if ($urandom_range(0, 3) == 0) send_burst_gap();
		end
	endtask

	task automatic set_search(int m, int m1, int m2, int a, int mode);
		set_reg(REG_TEST_COUNT, CFG_W'(m));
		set_reg(REG_FIRST_CAND, CFG_W'(m1));
		set_reg(REG_SECOND_CAND, CFG_W'(m2));
		set_reg(REG_ALPHA, CFG_W'(a));
		set_reg(REG_MODE, CFG_W'(mode));
	endtask

	initial begin
		int n, m1, m2;
		board = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: nothing found with empty ranges, then edge statistics and ties.
		start_search();
		drain();
		load(0, 32'h7FFFFFFF, 32'h80000000, 1);
		load(1, 32'h80000000, 32'h7FFFFFFF, 0);
		load(2, 32'h00010000, 32'h00010000, 2);
		load(3, 32'h00010000, 32'h00010000, 3);
		load(1023, 32'hFFFFFFFF, 32'h00000000, 1023);
		set_search(4, 4, 4, 65536, 0);
		start_search();
		drain();
		set_reg(REG_MODE, 64'd1);
		start_search();
		drain();
		set_search(0, 4, 4, 131071, 0);
		set_reg(REG_INIT_PROD, 64'h8000000000000000);
		start_search();
		drain();
		set_search(1024, 4, 4, 0, 1);
		start_search();
		drain();
		set_reg(REG_INIT_PROD, 64'h0000000000000000);
		set_search(1024, 4, 4, 131071, 0);
		start_search();
		drain();
		// Full-size search once, everything loaded.
		fill(1024);
		set_search(1024, 1024, 1024, 65536, 0);
		set_reg(REG_INIT_PROD, 64'h7FFFFFFFFFFFFFFF);
		start_search();
		drain();
		// Out-of-range candidate counts saturate.
		set_search(1024, 2047, 3, 3277, 1);
		start_search();
		drain();

		// Random phases: small sets, many loads, a search now and then.
		for (int ph = 0; ph < 15; ph++) begin
			stall_mode = ph % 4;
			n = $urandom_range(1, 24);
			m1 = $urandom_range(0, n);
			m2 = $urandom_range(0, n);
			set_search($urandom_range(0, 1024), m1, m2, $urandom_range(0, 131071),
				$urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				set_reg(REG_INIT_PROD, {$urandom, $urandom});
			fill(n);
			repeat ($urandom_range(1, 3)) begin
				start_search();
				if ($urandom_range(0, 1)) send_burst_gap();
			end
			// Overwrite a few entries inside the span without breaking the order.
			repeat ($urandom_range(0, 4))
				load($urandom_range(0, n - 1), $urandom, $urandom, $urandom_range(0, n - 1));
			start_search();
			drain();
		end

		drain();
		repeat (50) @(negedge clk);
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("paired_threshold_search_test: done, clean");
		else
			$display("paired_threshold_search_test: done, errors");
		$finish;
	end
endmodule

>>> paired_threshold_search.f
+incdir+hw/rtl
hw/rtl/pts_pkg.sv
hw/rtl/pts_pair_eval.sv
hw/rtl/paired_threshold_search.sv
hw/rtl/pts_checker.sv
sim/paired_threshold_search_test.sv
